### sv/c2p_dp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_dp_pkg
// Shared types, widths and codes for the dual-playfield chunky-to-planar block.
// ----------------------------------------------------------------------------
package c2p_dp_pkg;

   localparam int BYTE_W      = 8;
   localparam int NIBBLE_W    = 4;
   localparam int PLANES      = 8;
   localparam int MODE_W      = 2;
   localparam int DIM_W       = 11;
   localparam int STRIDE_W    = 12;
   localparam int OFFSET_W    = 22;
   localparam int GROUP_PIX   = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam int MAX_WIDTH_DEFAULT  = 1024;
   localparam int MAX_HEIGHT_DEFAULT = 1024;

   // upper bound of either frame dimension over the parameter range
   localparam int POS_LIMIT    = 4096;
   localparam int ROW_FIELD_W  = $clog2(POS_LIMIT);
   localparam int COLB_FIELD_W = $clog2(POS_LIMIT / GROUP_PIX);
   localparam int CMP_W        = ROW_FIELD_W + 1;

   localparam int QDEPTH   = 2;
   localparam int QPTR_W   = $clog2(QDEPTH);
   localparam int QCOUNT_W = $clog2(QDEPTH + 1);

   typedef logic [MODE_W-1:0] layout_type;
   localparam layout_type LAYOUT_PACKED = MODE_W'(0);
   localparam layout_type LAYOUT_BYTE   = MODE_W'(1);
   localparam layout_type LAYOUT_MIXED  = MODE_W'(2);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_DIM    = 2'd1,
      STATUS_BAD_STRIDE = 2'd2
   } status_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT_MODE      = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH      = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT     = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_PLANE_ROW_STRIDE = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] CSR_FRONT_ROW_STRIDE = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_BACK_ROW_STRIDE  = CSR_INDEX_W'(5);

   localparam logic [DIM_W-1:0]    RESET_FRAME_WIDTH  = DIM_W'(320);
   localparam logic [DIM_W-1:0]    RESET_FRAME_HEIGHT = DIM_W'(256);
   localparam logic [STRIDE_W-1:0] RESET_PLANE_STRIDE = STRIDE_W'(40);
   localparam logic [STRIDE_W-1:0] RESET_SRC_STRIDE   = STRIDE_W'(160);

   typedef logic [PLANES-1:0][BYTE_W-1:0] plane_set_type;

   typedef struct packed {
      layout_type          layout_mode;
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [STRIDE_W-1:0] plane_row_stride;
      logic [STRIDE_W-1:0] front_row_stride;
      logic [STRIDE_W-1:0] back_row_stride;
   } cfg_type;

   typedef struct packed {
      plane_set_type           planes;
      logic [ROW_FIELD_W-1:0]  row;
      logic [COLB_FIELD_W-1:0] col_byte;
      logic                    last;
      status_type              status;
   } group_type;

endpackage
`default_nettype wire

### sv/c2p_dp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_dp_req_if / c2p_dp_rsp_if
// Valid/ready channels for pixel requests and plane-group results.
// ----------------------------------------------------------------------------
interface c2p_dp_req_if import c2p_dp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] front_byte;
   logic [BYTE_W-1:0] back_byte;

   modport source (output valid, output front_byte, output back_byte, input ready);
   modport sink   (input valid, input front_byte, input back_byte, output ready);
endinterface

interface c2p_dp_rsp_if import c2p_dp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   plane_0;
   logic [BYTE_W-1:0]   plane_1;
   logic [BYTE_W-1:0]   plane_2;
   logic [BYTE_W-1:0]   plane_3;
   logic [BYTE_W-1:0]   plane_4;
   logic [BYTE_W-1:0]   plane_5;
   logic [BYTE_W-1:0]   plane_6;
   logic [BYTE_W-1:0]   plane_7;
   logic [OFFSET_W-1:0] byte_offset;
   logic                last_of_frame;
   logic [1:0]          status;

   modport source (output valid, output plane_0, output plane_1, output plane_2,
                   output plane_3, output plane_4, output plane_5, output plane_6,
                   output plane_7, output byte_offset, output last_of_frame,
                   output status, input ready);
   modport sink   (input valid, input plane_0, input plane_1, input plane_2,
                   input plane_3, input plane_4, input plane_5, input plane_6,
                   input plane_7, input byte_offset, input last_of_frame,
                   input status, output ready);
endinterface
`default_nettype wire

### sv/c2p_dp_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_dp_front
// Takes pixel requests, checks the configuration, tracks position and
// gathers plane bits; hands finished groups to the queue.
// ----------------------------------------------------------------------------
module c2p_dp_front import c2p_dp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   c2p_dp_req_if.sink req,
   output logic      push_valid,
   input  logic      push_ready,
   output group_type push_group
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   logic [COL_W-1:0]    column_ff, column_in;
   logic [ROW_W-1:0]    row_ff, row_in;
   plane_set_type       acc_ff, acc_in;

   status_type          status;
   logic                bad_dim, bad_stride, accept, emit, col_wrap, row_wrap;
   logic                front_packed, back_packed;
   logic [STRIDE_W-1:0] need_front, need_back;
   logic [NIBBLE_W-1:0] front_nib, back_nib;
   logic [BYTE_W-1:0]   bit_mask;
   logic [CMP_W-1:0]    column_inc, row_inc;
   plane_set_type       planes_new;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      unique case (cfg.layout_mode) inside
         LAYOUT_BYTE: begin
            front_packed = 1'b0;
            back_packed  = 1'b0;
         end
         LAYOUT_MIXED: begin
            front_packed = 1'b0;
            back_packed  = 1'b1;
         end
         default: begin
            front_packed = 1'b1;
            back_packed  = 1'b1;
         end
      endcase
      need_front = front_packed ? STRIDE_W'(cfg.frame_width >> 1) : STRIDE_W'(cfg.frame_width);
      need_back  = back_packed  ? STRIDE_W'(cfg.frame_width >> 1) : STRIDE_W'(cfg.frame_width);

      bad_dim = (cfg.frame_width == '0) || (cfg.frame_height == '0) ||
                (cfg.frame_width[2:0] != 3'd0) ||
                (CMP_W'(cfg.frame_width) > CMP_W'(MAX_WIDTH)) ||
                (CMP_W'(cfg.frame_height) > CMP_W'(MAX_HEIGHT));
      bad_stride = (cfg.plane_row_stride < STRIDE_W'(cfg.frame_width >> 3)) ||
                   (cfg.front_row_stride < need_front) ||
                   (cfg.back_row_stride < need_back);
      if (bad_dim) begin
         status = STATUS_BAD_DIM;
      end else if (bad_stride) begin
         status = STATUS_BAD_STRIDE;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      front_nib = (front_packed && !column_ff[0]) ? req.front_byte[7:4] : req.front_byte[3:0];
      back_nib  = (back_packed && !column_ff[0])  ? req.back_byte[7:4]  : req.back_byte[3:0];
      bit_mask  = BYTE_W'(8'h80 >> column_ff[2:0]);
      for (int k = 0; k < NIBBLE_W; k++) begin
         planes_new[2*k]   = acc_ff[2*k]   | (front_nib[k] ? bit_mask : '0);
         planes_new[2*k+1] = acc_ff[2*k+1] | (back_nib[k]  ? bit_mask : '0);
      end
      column_inc = CMP_W'(column_ff) + CMP_W'(1);
      row_inc    = CMP_W'(row_ff) + CMP_W'(1);
      col_wrap   = column_inc >= CMP_W'(cfg.frame_width);
      row_wrap   = row_inc >= CMP_W'(cfg.frame_height);
      emit       = column_ff[2:0] == 3'd7;
   end

   always_comb begin
      push_valid = accept && ((status != STATUS_OK) || emit);
      if (status != STATUS_OK) begin
         push_group.planes   = '0;
         push_group.row      = '0;
         push_group.col_byte = '0;
         push_group.last     = 1'b0;
      end else begin
         push_group.planes   = planes_new;
         push_group.row      = ROW_FIELD_W'(row_ff);
         push_group.col_byte = COLB_FIELD_W'(column_ff >> 3);
         push_group.last     = col_wrap && row_wrap;
      end
      push_group.status = status;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      acc_in    = acc_ff;
      if (accept) begin
         if (status != STATUS_OK) begin
            column_in = '0;
            row_in    = '0;
            acc_in    = '0;
         end else begin
            acc_in = emit ? '0 : planes_new;
            if (col_wrap) begin
               column_in = '0;
               row_in    = row_wrap ? '0 : ROW_W'(row_inc);
            end else begin
               column_in = COL_W'(column_inc);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         acc_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
         acc_ff    <= acc_in;
      end
   end

endmodule
`default_nettype wire

### sv/c2p_dp_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_dp_queue
// Short FIFO of finished plane groups between the front and back ends.
// ----------------------------------------------------------------------------
module c2p_dp_queue import c2p_dp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  group_type push_group,
   output logic      push_ready,
   input  logic      pop,
   output logic      head_valid,
   output group_type head_group
);

   group_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   assign push_ready = count_ff < QCOUNT_W'(QDEPTH);
   assign head_valid = count_ff != '0;
   assign head_group = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCOUNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCOUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> push_ready)
      else $error("group pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCOUNT_W'(QDEPTH))
      else $error("queue count beyond depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCOUNT_W'(1)))
      else $error("queue count lost a push");

endmodule
`default_nettype wire

### sv/c2p_dp_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_dp_back
// Pops plane groups, forms the destination offset and holds the result.
// ----------------------------------------------------------------------------
module c2p_dp_back import c2p_dp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [STRIDE_W-1:0] plane_row_stride,
   input  logic                head_valid,
   input  group_type           head_group,
   output logic                pop,
   c2p_dp_rsp_if.source        rsp
);

   logic                              out_valid_ff, out_valid_in;
   plane_set_type                     planes_ff;
   logic [OFFSET_W-1:0]               offset_ff, offset_in;
   logic                              last_ff;
   status_type                        status_ff;
   logic [ROW_FIELD_W+STRIDE_W-1:0]   product;

   assign pop          = head_valid && (!out_valid_ff || rsp.ready);
   assign out_valid_in = pop || (out_valid_ff && !rsp.ready);
   assign product      = (ROW_FIELD_W + STRIDE_W)'(head_group.row) *
                         (ROW_FIELD_W + STRIDE_W)'(plane_row_stride);
   assign offset_in    = OFFSET_W'(product) + OFFSET_W'(head_group.col_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         planes_ff <= head_group.planes;
         offset_ff <= offset_in;
         last_ff   <= head_group.last;
         status_ff <= head_group.status;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.plane_0       = planes_ff[0];
   assign rsp.plane_1       = planes_ff[1];
   assign rsp.plane_2       = planes_ff[2];
   assign rsp.plane_3       = planes_ff[3];
   assign rsp.plane_4       = planes_ff[4];
   assign rsp.plane_5       = planes_ff[5];
   assign rsp.plane_6       = planes_ff[6];
   assign rsp.plane_7       = planes_ff[7];
   assign rsp.byte_offset   = offset_ff;
   assign rsp.last_of_frame = last_ff;
   assign rsp.status        = status_ff;

endmodule
`default_nettype wire

### sv/chunky_to_planar_dual_playfield_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chunky_to_planar_dual_playfield_top
// Dual-playfield chunky-to-planar converter with register file.
// ----------------------------------------------------------------------------
// One pixel request is taken every clock while the group queue has room. Each
// eighth pixel of a row yields one result of eight plane bytes and its
// destination offset; while the configuration is invalid every request
// yields a result with a status code. A completed result is written from the
// front end into the group queue and passes through the offset multiplier
// into the output register. A stalled result side backs up the two-entry
// queue before requests are held off.
// ----------------------------------------------------------------------------
module chunky_to_planar_dual_playfield_top import c2p_dp_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEFAULT,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   c2p_dp_req_if.sink             req_bus,
   c2p_dp_rsp_if.source           rsp_bus,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready, pop, head_valid;
   group_type push_group, head_group;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LAYOUT_MODE:      cfg_in.layout_mode      = MODE_W'(csr_wdata);
            CSR_FRAME_WIDTH:      cfg_in.frame_width      = DIM_W'(csr_wdata);
            CSR_FRAME_HEIGHT:     cfg_in.frame_height     = DIM_W'(csr_wdata);
            CSR_PLANE_ROW_STRIDE: cfg_in.plane_row_stride = STRIDE_W'(csr_wdata);
            CSR_FRONT_ROW_STRIDE: cfg_in.front_row_stride = STRIDE_W'(csr_wdata);
            CSR_BACK_ROW_STRIDE:  cfg_in.back_row_stride  = STRIDE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.layout_mode      <= LAYOUT_PACKED;
         cfg_ff.frame_width      <= RESET_FRAME_WIDTH;
         cfg_ff.frame_height     <= RESET_FRAME_HEIGHT;
         cfg_ff.plane_row_stride <= RESET_PLANE_STRIDE;
         cfg_ff.front_row_stride <= RESET_SRC_STRIDE;
         cfg_ff.back_row_stride  <= RESET_SRC_STRIDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   c2p_dp_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_group (push_group)
   );

   c2p_dp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_valid),
      .push_group (push_group),
      .push_ready (push_ready),
      .pop        (pop),
      .head_valid (head_valid),
      .head_group (head_group)
   );

   c2p_dp_back u_back (
      .clock            (clock),
      .reset            (reset),
      .plane_row_stride (cfg_ff.plane_row_stride),
      .head_valid       (head_valid),
      .head_group       (head_group),
      .pop              (pop),
      .rsp              (rsp_bus)
   );

endmodule
`default_nettype wire
